### hdl/skf_pkg.sv
package skf_pkg;

   typedef logic signed [15:0] coef_type;    // Q4.12
   typedef logic        [31:0] cov_type;     // unsigned Q16.16
   typedef logic signed [31:0] est_type;     // Q23.8
   typedef logic signed [57:0] prod_type;    // 18 x 40 multiplier product
   typedef logic signed [65:0] wide_type;    // accumulator

   // register map, index = paddr[4:2]
   localparam logic [2:0] REG_MODEL_COEF       = 3'd0;
   localparam logic [2:0] REG_OBSERVE_COEF     = 3'd1;
   localparam logic [2:0] REG_PROCESS_NOISE    = 3'd2;
   localparam logic [2:0] REG_MEASURE_NOISE    = 3'd3;
   localparam logic [2:0] REG_START_ESTIMATE   = 3'd4;
   localparam logic [2:0] REG_START_COVARIANCE = 3'd5;

   localparam coef_type RST_MODEL_COEF       = 16'sd4096;
   localparam coef_type RST_OBSERVE_COEF     = 16'sd4096;
   localparam cov_type  RST_PROCESS_NOISE    = 32'd327680;
   localparam cov_type  RST_MEASURE_NOISE    = 32'd7864320;
   localparam est_type  RST_START_ESTIMATE   = 32'sd0;
   localparam cov_type  RST_START_COVARIANCE = 32'd0;

   // 1.0 in Q8.24
   localparam logic signed [32:0] ONE_Q24 = 33'sd16777216;

   function automatic est_type sat_s32(input wide_type v);
      if (v > 66'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -66'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return est_type'(v[31:0]);
      end
   endfunction

   function automatic cov_type sat_u32(input wide_type v);
      if (v < 66'sd0) begin
         return 32'd0;
      end else if (v > 66'sd4294967295) begin
         return 32'hFFFF_FFFF;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

### hdl/scalar_kalman_filter_unit.sv
// channel  | handshake              | payload
// ---------+------------------------+-----------------------------------------------
// req      | req_tvalid/req_tready  | tuser: channel; tdata: measurement
// rsp      | rsp_tvalid/rsp_tready  | tuser: out_channel; tdata: estimate,
//          |                        |   covariance, kalman_gain
// csr      | psel/penable, pready=1 | six 32-bit registers at 4*i
//
// From accept to result, one word passes through 11 steps on the shared 18x40
// multiplier, a divide check, a 16-step restoring divider, a gain step, then 7 more
// multiplier and saturation steps; the next word is taken once the sequencer is idle.
// A saturated gain skips the divider; a zero denominator also skips the gain step.
// req_tready is high only while the sequencer is idle; a word on an unused channel is
// taken and dropped. The result waits in an output register, so the next word is taken
// while it is unread; the last step holds if the previous result is still unread.
// Reset loads the register defaults and clears every channel to the start values.
module scalar_kalman_filter_unit #(
   parameter int CHANNELS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,     // [31:0] measurement
   input  logic [1:0]  req_tuser,     // [1:0] channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,     // [31:0] estimate, [63:32] covariance,
                                      // [79:64] kalman_gain
   output logic [1:0]  rsp_tuser,     // [1:0] out_channel
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_M1   = 5'd1;
   localparam logic [4:0] ST_M2   = 5'd2;
   localparam logic [4:0] ST_M3   = 5'd3;
   localparam logic [4:0] ST_M4   = 5'd4;
   localparam logic [4:0] ST_M5   = 5'd5;
   localparam logic [4:0] ST_M6   = 5'd6;
   localparam logic [4:0] ST_M7   = 5'd7;
   localparam logic [4:0] ST_M8   = 5'd8;
   localparam logic [4:0] ST_M9   = 5'd9;
   localparam logic [4:0] ST_M10  = 5'd10;
   localparam logic [4:0] ST_M11  = 5'd11;
   localparam logic [4:0] ST_DCHK = 5'd12;
   localparam logic [4:0] ST_DIV  = 5'd13;
   localparam logic [4:0] ST_GAIN = 5'd14;
   localparam logic [4:0] ST_U1   = 5'd15;
   localparam logic [4:0] ST_U2   = 5'd16;
   localparam logic [4:0] ST_U3   = 5'd17;
   localparam logic [4:0] ST_U4   = 5'd18;
   localparam logic [4:0] ST_U5   = 5'd19;
   localparam logic [4:0] ST_U6   = 5'd20;
   localparam logic [4:0] ST_FIN  = 5'd21;

   // configuration
   skf_pkg::coef_type a_ff;
   skf_pkg::coef_type h_ff;
   skf_pkg::cov_type  q_ff;
   skf_pkg::cov_type  r_ff;
   skf_pkg::est_type  x0_ff;
   skf_pkg::cov_type  p0_ff;

   // per-channel state
   skf_pkg::est_type  est_ff [CHANNELS];
   skf_pkg::cov_type  cov_ff [CHANNELS];

   // sequencer and datapath
   logic [4:0]             state_ff;
   logic [4:0]             state_in;
   logic [1:0]             ch_ff;
   logic [CH_W-1:0]        idx_ff;
   skf_pkg::est_type       z_ff;
   skf_pkg::est_type       x_ff;
   skf_pkg::cov_type       p_ff;
   skf_pkg::est_type       x1_ff;
   logic [30:0]            aa_ff;
   logic [30:0]            hh_ff;
   skf_pkg::cov_type       p1_ff;
   logic signed [39:0]     innov_ff;
   logic [39:0]            den_ff;
   logic                   neg_ff;
   logic [47:0]            mag_ff;
   logic                   ovf_ff;
   logic [39:0]            rem_ff;
   logic [15:0]            dq_ff;
   logic [3:0]             cnt_ff;
   skf_pkg::coef_type      gain_ff;
   skf_pkg::est_type       x2_ff;
   logic signed [32:0]     f_ff;
   skf_pkg::prod_type      prod_ff;
   skf_pkg::wide_type      acc_ff;

   // output register
   logic                   rsp_tvalid_ff;
   logic [1:0]             rsp_ch_ff;
   skf_pkg::est_type       rsp_est_ff;
   skf_pkg::cov_type       rsp_cov_ff;
   skf_pkg::coef_type      rsp_gain_ff;

   logic                   req_fire;
   logic                   ch_ok;
   logic [CH_W-1:0]        req_idx;
   logic                   csr_wr;
   logic                   fin_go;
   logic signed [17:0]     mul_a;
   logic signed [39:0]     mul_b;
   skf_pkg::prod_type      mul_p;
   skf_pkg::wide_type      prod_w;
   skf_pkg::prod_type      prod_abs;
   logic [40:0]            rem_sh;
   logic [40:0]            rem_diff;
   logic                   rem_ge;
   skf_pkg::cov_type       p2;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign ch_ok      = (32'(req_tuser) < 32'(CHANNELS));
   assign req_idx    = CH_W'(req_tuser);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign fin_go     = !rsp_tvalid_ff || rsp_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_ch_ff;
   assign rsp_tdata  = {rsp_gain_ff, rsp_cov_ff, rsp_est_ff};

   // ---------------- configuration port ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff  <= skf_pkg::RST_MODEL_COEF;
         h_ff  <= skf_pkg::RST_OBSERVE_COEF;
         q_ff  <= skf_pkg::RST_PROCESS_NOISE;
         r_ff  <= skf_pkg::RST_MEASURE_NOISE;
         x0_ff <= skf_pkg::RST_START_ESTIMATE;
         p0_ff <= skf_pkg::RST_START_COVARIANCE;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            skf_pkg::REG_MODEL_COEF:       a_ff  <= csr_pwdata[15:0];
            skf_pkg::REG_OBSERVE_COEF:     h_ff  <= csr_pwdata[15:0];
            skf_pkg::REG_PROCESS_NOISE:    q_ff  <= csr_pwdata;
            skf_pkg::REG_MEASURE_NOISE:    r_ff  <= csr_pwdata;
            skf_pkg::REG_START_ESTIMATE:   x0_ff <= csr_pwdata;
            skf_pkg::REG_START_COVARIANCE: p0_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         skf_pkg::REG_MODEL_COEF:       csr_prdata = {16'h0000, a_ff};
         skf_pkg::REG_OBSERVE_COEF:     csr_prdata = {16'h0000, h_ff};
         skf_pkg::REG_PROCESS_NOISE:    csr_prdata = q_ff;
         skf_pkg::REG_MEASURE_NOISE:    csr_prdata = r_ff;
         skf_pkg::REG_START_ESTIMATE:   csr_prdata = x0_ff;
         skf_pkg::REG_START_COVARIANCE: csr_prdata = p0_ff;
         default:                       csr_prdata = 32'h0000_0000;
      endcase
   end

   // ---------------- channel stores ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            est_ff[i] <= skf_pkg::RST_START_ESTIMATE;
            cov_ff[i] <= skf_pkg::RST_START_COVARIANCE;
         end
      end else if (csr_wr && csr_paddr[4:2] == skf_pkg::REG_START_ESTIMATE) begin
         for (int i = 0; i < CHANNELS; i++) begin
            est_ff[i] <= csr_pwdata;
         end
      end else if (csr_wr && csr_paddr[4:2] == skf_pkg::REG_START_COVARIANCE) begin
         for (int i = 0; i < CHANNELS; i++) begin
            cov_ff[i] <= csr_pwdata;
         end
      end else if (state_ff == ST_FIN && fin_go) begin
         est_ff[idx_ff] <= x2_ff;
         cov_ff[idx_ff] <= p2;
      end
   end

   // ---------------- shared multiplier ----------------
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_M1: begin
            mul_a = {{2{a_ff[15]}}, a_ff};
            mul_b = 40'(x_ff);
         end
         ST_M2: begin
            mul_a = {{2{a_ff[15]}}, a_ff};
            mul_b = 40'(a_ff);
         end
         ST_M3: begin
            mul_a = {{2{h_ff[15]}}, h_ff};
            mul_b = 40'(h_ff);
         end
         ST_M4: begin
            mul_a = {2'b00, aa_ff[15:0]};
            mul_b = {8'h00, p_ff};
         end
         ST_M5: begin
            mul_a = {3'b000, aa_ff[30:16]};
            mul_b = {8'h00, p_ff};
         end
         ST_M6: begin
            mul_a = {{2{h_ff[15]}}, h_ff};
            mul_b = 40'(x1_ff);
         end
         ST_M8: begin
            mul_a = {2'b00, hh_ff[15:0]};
            mul_b = {8'h00, p1_ff};
         end
         ST_M9: begin
            mul_a = {3'b000, hh_ff[30:16]};
            mul_b = {8'h00, p1_ff};
         end
         ST_M10: begin
            mul_a = {{2{h_ff[15]}}, h_ff};
            mul_b = {8'h00, p1_ff};
         end
         ST_U1: begin
            mul_a = {{2{gain_ff[15]}}, gain_ff};
            mul_b = innov_ff;
         end
         ST_U2: begin
            mul_a = {{2{gain_ff[15]}}, gain_ff};
            mul_b = 40'(h_ff);
         end
         ST_U4: begin
            mul_a = {2'b00, p1_ff[15:0]};
            mul_b = 40'(f_ff);
         end
         ST_U5: begin
            mul_a = {2'b00, p1_ff[31:16]};
            mul_b = 40'(f_ff);
         end
         default: ;
      endcase
   end

   assign mul_p    = mul_a * mul_b;
   assign prod_w   = 66'(prod_ff);
   assign prod_abs = prod_ff[57] ? -prod_ff : prod_ff;

   // restoring divider step
   assign rem_sh   = {rem_ff, dq_ff[15]};
   assign rem_diff = rem_sh - {1'b0, den_ff};
   assign rem_ge   = (rem_sh >= {1'b0, den_ff});

   assign p2 = skf_pkg::sat_u32(acc_ff >>> 24);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire && ch_ok) begin
            state_in = ST_M1;
         end
         ST_M1:   state_in = ST_M2;
         ST_M2:   state_in = ST_M3;
         ST_M3:   state_in = ST_M4;
         ST_M4:   state_in = ST_M5;
         ST_M5:   state_in = ST_M6;
         ST_M6:   state_in = ST_M7;
         ST_M7:   state_in = ST_M8;
         ST_M8:   state_in = ST_M9;
         ST_M9:   state_in = ST_M10;
         ST_M10:  state_in = ST_M11;
         ST_M11:  state_in = ST_DCHK;
         ST_DCHK: begin
            if (den_ff == '0) begin
               state_in = ST_U1;
            end else if ({8'h00, mag_ff[47:16]} >= den_ff) begin
               state_in = ST_GAIN;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV:  if (cnt_ff == 4'd15) begin
            state_in = ST_GAIN;
         end
         ST_GAIN: state_in = ST_U1;
         ST_U1:   state_in = ST_U2;
         ST_U2:   state_in = ST_U3;
         ST_U3:   state_in = ST_U4;
         ST_U4:   state_in = ST_U5;
         ST_U5:   state_in = ST_U6;
         ST_U6:   state_in = ST_FIN;
         ST_FIN:  if (fin_go) begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- datapath ----------------
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      case (state_ff)
         ST_IDLE: if (req_fire && ch_ok) begin
            ch_ff  <= req_tuser;
            idx_ff <= req_idx;
            z_ff   <= req_tdata;
            x_ff   <= est_ff[req_idx];
            p_ff   <= cov_ff[req_idx];
         end
         ST_M2:  x1_ff <= skf_pkg::sat_s32(prod_w >>> 12);
         ST_M3:  aa_ff <= prod_ff[30:0];
         ST_M4:  hh_ff <= prod_ff[30:0];
         ST_M5:  acc_ff <= prod_w;
         ST_M6:  acc_ff <= acc_ff + (prod_w <<< 16);
         ST_M7: begin
            // predicted covariance, and innovation z - H*x1
            p1_ff    <= skf_pkg::sat_u32((acc_ff >>> 24) + $signed({34'd0, q_ff}));
            innov_ff <= 40'(z_ff) - 40'(prod_w >>> 12);
         end
         ST_M9:  acc_ff <= prod_w;
         ST_M10: acc_ff <= acc_ff + (prod_w <<< 16);
         ST_M11: begin
            den_ff <= 40'(acc_ff >>> 24) + {8'h00, r_ff};
            neg_ff <= prod_ff[57];
            mag_ff <= prod_abs[47:0];
         end
         ST_DCHK: begin
            gain_ff <= '0;
            ovf_ff  <= ({8'h00, mag_ff[47:16]} >= den_ff);
            rem_ff  <= {8'h00, mag_ff[47:16]};
            dq_ff   <= mag_ff[15:0];
            cnt_ff  <= '0;
         end
         ST_DIV: begin
            rem_ff <= rem_ge ? rem_diff[39:0] : rem_sh[39:0];
            dq_ff  <= {dq_ff[14:0], rem_ge};
            cnt_ff <= cnt_ff + 4'd1;
         end
         ST_GAIN: begin
            if (ovf_ff) begin
               gain_ff <= neg_ff ? 16'sh8000 : 16'sh7FFF;
            end else if (!neg_ff) begin
               gain_ff <= dq_ff[15] ? 16'sh7FFF : dq_ff;
            end else begin
               gain_ff <= (dq_ff > 16'h8000) ? 16'sh8000 : -dq_ff;
            end
         end
         ST_U2:  x2_ff <= skf_pkg::sat_s32(66'(x1_ff) + (prod_w >>> 12));
         ST_U3:  f_ff <= skf_pkg::ONE_Q24 - 33'(prod_ff);
         ST_U5:  acc_ff <= prod_w;
         ST_U6:  acc_ff <= acc_ff + (prod_w <<< 16);
         default: ;
      endcase
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (state_ff == ST_FIN && fin_go) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN && fin_go) begin
         rsp_ch_ff   <= ch_ff;
         rsp_est_ff  <= x2_ff;
         rsp_cov_ff  <= p2;
         rsp_gain_ff <= gain_ff;
      end
   end

   // ---------------- assertions ----------------
   a_div_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder not below denominator");

   a_zero_den_gain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DCHK && den_ff == '0) |=> (state_ff == ST_U1 && gain_ff == '0))
      else $error("zero denominator did not force zero gain");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_fire && ch_ok) |=> (!req_tready && state_ff == ST_M1))
      else $error("sequencer did not start on accepted word");

   a_result_written_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && fin_go) |=> (rsp_tvalid_ff && state_ff == ST_IDLE))
      else $error("result not presented after final step");

endmodule
